FILE: rtl/hkat_pkg.sv
// shared types and constants for the handle key allocator table
`default_nettype none

package hkat_pkg;

    localparam int ACTION_W = 2;
    localparam int KEY_FIELD_W = 8;
    localparam int VALUE_FIELD_W = 32;
    localparam int COUNT_FIELD_W = 8;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_GET    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic clear_step;
        logic scan_step;
        logic finish_look;
        logic finish_scan;
    } hkat_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic start_scan;
        logic hit;
        logic res_free;
    } hkat_stat_t;

endpackage

`default_nettype wire

FILE: rtl/hkat_if.sv
// request and result channel interfaces
`default_nettype none

interface hkat_req_if
    import hkat_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [ACTION_W-1:0]      action;
    logic [KEY_FIELD_W-1:0]   req_key;
    logic [VALUE_FIELD_W-1:0] req_value;

    modport source (output valid, output action, output req_key, output req_value,
                    input ready);
    modport sink   (input valid, input action, input req_key, input req_value,
                    output ready);
endinterface

interface hkat_res_if
    import hkat_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [KEY_FIELD_W-1:0]   issued_key;
    logic [VALUE_FIELD_W-1:0] read_value;
    logic                     found;
    logic                     full_res;
    logic [COUNT_FIELD_W-1:0] live_count;

    modport source (output valid, output issued_key, output read_value, output found,
                    output full_res, output live_count, input ready);
    modport sink   (input valid, input issued_key, input read_value, input found,
                    input full_res, input live_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/hkat_ctrl.sv
// controller state machine of the handle key allocator table
`default_nettype none

module hkat_ctrl
    import hkat_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire hkat_stat_t stat,
    output hkat_cmd_t       cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;
    localparam logic [1:0] ST_SCAN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.start_scan ? ST_SCAN : ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (stat.res_free)
                begin
                    cmd.finish_look = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (!stat.hit)
                begin
                    cmd.scan_step = 1'b1;
                end
                else if (stat.res_free)
                begin
                    cmd.finish_scan = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hkat_dp.sv
// datapath of the handle key allocator table: slot memory, pointers, count, result register
`default_nettype none

module hkat_dp
    import hkat_pkg::*;
#(
    parameter int KEY_SLOTS  = 256,
    parameter int VALUE_BITS = 32
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire hkat_cmd_t                cmd,
    output hkat_stat_t                    stat,
    input  wire logic [ACTION_W-1:0]      action,
    input  wire logic [KEY_FIELD_W-1:0]   req_key,
    input  wire logic [VALUE_FIELD_W-1:0] req_value,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [KEY_FIELD_W-1:0]        issued_key,
    output logic [VALUE_FIELD_W-1:0]      read_value,
    output logic                          found,
    output logic                          full_res,
    output logic [COUNT_FIELD_W-1:0]      live_count
);

    localparam int KEY_W = $clog2(KEY_SLOTS);
    localparam logic [KEY_W-1:0] KEY_LAST = KEY_W'(KEY_SLOTS - 1);

    function automatic logic [KEY_W-1:0] key_inc(input logic [KEY_W-1:0] k);
        return (k == KEY_LAST) ? '0 : k + 1'b1;
    endfunction

    // slot word: in-use flag over value
    logic [VALUE_BITS:0] slot_mem [KEY_SLOTS];
    logic [VALUE_BITS:0] rd_word_reg;

    logic [KEY_W-1:0]      next_key_reg;
    logic [KEY_W-1:0]      count_reg;
    logic [KEY_W-1:0]      clr_ptr_reg;
    logic [KEY_W-1:0]      chk_addr_reg;
    logic [KEY_W-1:0]      scan_ptr_reg;
    logic [ACTION_W-1:0]   act_reg;
    logic                  in_range_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic                  out_valid_reg;

    logic [KEY_FIELD_W-1:0]   issued_key_reg;
    logic [VALUE_FIELD_W-1:0] read_value_reg;
    logic                     found_reg;
    logic                     full_res_reg;
    logic [COUNT_FIELD_W-1:0] live_count_reg;

    logic             table_full;
    logic             rd_en;
    logic [KEY_W-1:0] rd_addr;
    logic             wr_en;
    logic [KEY_W-1:0] wr_addr;
    logic [VALUE_BITS:0] wr_word;
    logic             key_hit;
    logic             remove_hit;

    assign table_full = (count_reg == KEY_LAST);
    assign key_hit    = in_range_reg && rd_word_reg[VALUE_BITS];
    assign remove_hit = (act_reg == ACT_REMOVE) && key_hit;

    assign stat.clear_last = (clr_ptr_reg == KEY_LAST);
    assign stat.start_scan = (action == ACT_ADD) && !table_full;
    assign stat.hit        = !rd_word_reg[VALUE_BITS] && (chk_addr_reg != '0);
    assign stat.res_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        rd_en   = cmd.accept || cmd.scan_step;
        rd_addr = scan_ptr_reg;
        if (cmd.accept)
        begin
            rd_addr = stat.start_scan ? next_key_reg : KEY_W'(req_key);
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = chk_addr_reg;
        wr_word = '0;
        priority if (cmd.clear_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_ptr_reg;
        end
        else if (cmd.finish_scan)
        begin
            wr_en   = 1'b1;
            wr_word = {1'b1, val_reg};
        end
        else if (cmd.finish_look && remove_hit)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg <= slot_mem[rd_addr];
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            act_reg      <= action;
            in_range_reg <= (32'(req_key) < 32'(KEY_SLOTS));
            val_reg      <= VALUE_BITS'(req_value);
            chk_addr_reg <= stat.start_scan ? next_key_reg : KEY_W'(req_key);
            scan_ptr_reg <= key_inc(next_key_reg);
        end
        else if (cmd.scan_step)
        begin
            chk_addr_reg <= scan_ptr_reg;
            scan_ptr_reg <= key_inc(scan_ptr_reg);
        end
        if (cmd.finish_scan)
        begin
            issued_key_reg <= KEY_FIELD_W'(chk_addr_reg);
            read_value_reg <= '0;
            found_reg      <= 1'b0;
            full_res_reg   <= 1'b0;
            live_count_reg <= COUNT_FIELD_W'(count_reg + 1'b1);
        end
        else if (cmd.finish_look)
        begin
            issued_key_reg <= '0;
            read_value_reg <= ((act_reg == ACT_GET) && key_hit)
                              ? VALUE_FIELD_W'(rd_word_reg[VALUE_BITS-1:0]) : '0;
            found_reg      <= ((act_reg == ACT_GET) || (act_reg == ACT_REMOVE)) && key_hit;
            full_res_reg   <= (act_reg == ACT_ADD);
            live_count_reg <= COUNT_FIELD_W'(remove_hit ? count_reg - 1'b1 : count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_key_reg  <= KEY_W'(1);
            count_reg     <= '0;
            clr_ptr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_ptr_reg <= key_inc(clr_ptr_reg);
            end
            if (cmd.finish_scan)
            begin
                next_key_reg <= key_inc(chk_addr_reg);
                count_reg    <= count_reg + 1'b1;
            end
            else if (cmd.finish_look && remove_hit)
            begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.finish_scan || cmd.finish_look)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign issued_key = issued_key_reg;
    assign read_value = read_value_reg;
    assign found      = found_reg;
    assign full_res   = full_res_reg;
    assign live_count = live_count_reg;

endmodule

`default_nettype wire

FILE: rtl/handle_key_allocator_table.sv
// top level of the handle key allocator table
//
//  channel | dir | beat fields                                        | handshake
//  --------+-----+----------------------------------------------------+--------------
//  req     | in  | action, req_key, req_value                         | valid / ready
//  res     | out | issued_key, read_value, found, full_res, live_count| valid / ready
//
// get, remove, unknown action and add on a full table: LOOK state, then the result
// add: SCAN state, skipping keys that are key 0 or in use; the slot memory read
//   port checks one candidate key per cycle
// after reset a clearing pass writes every slot, with req.ready low
// a new request is taken while the previous result beat still waits in the output
//   register; a stalled result holds the finishing step until the register frees up
`default_nettype none

module handle_key_allocator_table
    import hkat_pkg::*;
#(
    parameter int KEY_SLOTS  = 256,
    parameter int VALUE_BITS = 32
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    hkat_req_if.sink    req,
    hkat_res_if.source  res
);

    // command and status between controller and datapath
    hkat_cmd_t  cmd;
    hkat_stat_t stat;

    hkat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // slot memory holds the in-use flag and value of each key
    hkat_dp #(
        .KEY_SLOTS  (KEY_SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .action     (req.action),
        .req_key    (req.req_key),
        .req_value  (req.req_value),
        .out_valid  (res.valid),
        .out_ready  (res.ready),
        .issued_key (res.issued_key),
        .read_value (res.read_value),
        .found      (res.found),
        .full_res   (res.full_res),
        .live_count (res.live_count)
    );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// self-checking bench for the handle key allocator table
`default_nettype none

module tb_top
    import hkat_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // action code that the block must treat as a no-op
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

    // the nonzero keys, all of them live means the table is full
    localparam logic [COUNT_FIELD_W-1:0] TABLE_CAP = 8'd255;

    // settle time after the last result
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [KEY_FIELD_W-1:0]   issued_key;
        logic [VALUE_FIELD_W-1:0] read_value;
        logic                     found;
        logic                     full_res;
        logic [COUNT_FIELD_W-1:0] live_count;
    } table_result_t;

    // one row of the directed sequence, pinned rows carry a hand-typed result
    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic [KEY_FIELD_W-1:0]   req_key;
        logic [VALUE_FIELD_W-1:0] req_value;
        logic                     pinned;
        table_result_t            result;
    } plan_row_t;

    localparam int PLAN_LEN = 23;

    localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
        // empty table right after reset: key zero, top key, unknown action
        '{ACT_GET,    8'd0,   32'h0000_0000, 1'b1, '{8'd0, 32'h0, 1'b0, 1'b0, 8'd0}},
        '{ACT_REMOVE, 8'd0,   32'h0000_0000, 1'b1, '{8'd0, 32'h0, 1'b0, 1'b0, 8'd0}},
        '{ACT_GET,    8'd255, 32'hffff_ffff, 1'b1, '{8'd0, 32'h0, 1'b0, 1'b0, 8'd0}},
        '{ACT_REMOVE, 8'd255, 32'hffff_ffff, 1'b1, '{8'd0, 32'h0, 1'b0, 1'b0, 8'd0}},
        '{ACT_NONE,   8'd255, 32'hffff_ffff, 1'b1, '{8'd0, 32'h0, 1'b0, 1'b0, 8'd0}},
        // first keys come out in order, value extremes stored
        '{ACT_ADD,    8'd0,   32'h0000_0000, 1'b1, '{8'd1, 32'h0, 1'b0, 1'b0, 8'd1}},
        '{ACT_ADD,    8'd255, 32'hffff_ffff, 1'b1, '{8'd2, 32'h0, 1'b0, 1'b0, 8'd2}},
        '{ACT_ADD,    8'd0,   32'h8000_0001, 1'b1, '{8'd3, 32'h0, 1'b0, 1'b0, 8'd3}},
        '{ACT_GET,    8'd1,   32'hffff_ffff, 1'b1,
          '{8'd0, 32'h0000_0000, 1'b1, 1'b0, 8'd3}},
        '{ACT_GET,    8'd2,   32'h0000_0000, 1'b1,
          '{8'd0, 32'hffff_ffff, 1'b1, 1'b0, 8'd3}},
        '{ACT_NONE,   8'd2,   32'h0000_0000, 1'b1, '{8'd0, 32'h0, 1'b0, 1'b0, 8'd3}},
        // free a key, then it reads as absent and a second free misses
        '{ACT_REMOVE, 8'd2,   32'h0000_0000, 1'b1, '{8'd0, 32'h0, 1'b1, 1'b0, 8'd2}},
        '{ACT_GET,    8'd2,   32'h0000_0000, 1'b1, '{8'd0, 32'h0, 1'b0, 1'b0, 8'd2}},
        '{ACT_REMOVE, 8'd2,   32'h0000_0000, 1'b1, '{8'd0, 32'h0, 1'b0, 1'b0, 8'd2}},
        // pointer keeps moving forward, the freed key is not reused yet
        '{ACT_ADD,    8'd2,   32'h1234_5678, 1'b1, '{8'd4, 32'h0, 1'b0, 1'b0, 8'd3}},
        '{ACT_GET,    8'd3,   32'h0000_0000, 1'b1,
          '{8'd0, 32'h8000_0001, 1'b1, 1'b0, 8'd3}},
        // the rest of the rows go through the predictor
        '{ACT_ADD,    8'd0,   32'h5a5a_a5a5, 1'b0, '0},
        '{ACT_GET,    8'd5,   32'h0000_0000, 1'b0, '0},
        '{ACT_REMOVE, 8'd1,   32'h0000_0000, 1'b0, '0},
        '{ACT_REMOVE, 8'd3,   32'h0000_0000, 1'b0, '0},
        '{ACT_GET,    8'd4,   32'h0000_0000, 1'b0, '0},
        '{ACT_REMOVE, 8'd4,   32'h0000_0000, 1'b0, '0},
        '{ACT_ADD,    8'd128, 32'hc3c3_3c3c, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    hkat_req_if req_ch ();
    hkat_res_if res_ch ();

    handle_key_allocator_table i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the table: allocation pointer, busy flags, stored words, live count
    logic [KEY_FIELD_W-1:0]   alloc_ptr;
    logic                     key_busy [256];
    logic [VALUE_FIELD_W-1:0] key_word [256];
    logic [COUNT_FIELD_W-1:0] busy_count;

    // results still owed by the block, oldest first
    table_result_t pending_results [$];

    int fail_count = 0;

    // idling knobs, percent of cycles
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // long receiver hold-off, counted down by the receiver process
    int hold_cycles = 0;

    // apply one accepted request to the shadow table and return its result beat
    function automatic table_result_t apply_request(
        input logic [ACTION_W-1:0]      act,
        input logic [KEY_FIELD_W-1:0]   key,
        input logic [VALUE_FIELD_W-1:0] word
    );
        table_result_t r;
        logic [KEY_FIELD_W-1:0] cand;
        r = '0;
        case (act)
            ACT_ADD:
            begin
                if (busy_count == TABLE_CAP)
                begin
                    r.full_res = 1'b1;
                end
                else
                begin
                    // walk forward with wrap, skipping key zero and live keys
                    cand = alloc_ptr;
                    while (cand == '0 || key_busy[cand])
                        cand = cand + 1'b1;
                    key_busy[cand] = 1'b1;
                    key_word[cand] = word;
                    busy_count = busy_count + 1'b1;
                    alloc_ptr = cand + 1'b1;
                    r.issued_key = cand;
                end
            end
            ACT_GET:
            begin
                if (key_busy[key])
                begin
                    r.found = 1'b1;
                    r.read_value = key_word[key];
                end
            end
            ACT_REMOVE:
            begin
                if (key_busy[key])
                begin
                    r.found = 1'b1;
                    key_busy[key] = 1'b0;
                    busy_count = busy_count - 1'b1;
                end
            end
            default:
            begin
                // unknown action leaves the table alone
            end
        endcase
        r.live_count = busy_count;
        return r;
    endfunction

    // random live key, or any nonzero key when the table is empty
    function automatic logic [KEY_FIELD_W-1:0] pick_live_key();
        logic [KEY_FIELD_W-1:0] k;
        k = KEY_FIELD_W'($urandom_range(255, 1));
        if (busy_count == '0)
            return k;
        for (int i = 0; i < 256; i++)
        begin
            if (key_busy[k])
                return k;
            k = k + 1'b1;
        end
        return k;
    endfunction

    // value words lean on the extremes now and then
    function automatic logic [VALUE_FIELD_W-1:0] pick_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // offer one request beat, with random gaps before it, and log its result
    task automatic issue_request(
        input logic [ACTION_W-1:0]      act,
        input logic [KEY_FIELD_W-1:0]   key,
        input logic [VALUE_FIELD_W-1:0] word,
        input logic                     pinned,
        input table_result_t            pinned_result
    );
        table_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid     <= 1'b1;
        req_ch.action    <= act;
        req_ch.req_key   <= key;
        req_ch.req_value <= word;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // beat taken at this edge, update the shadow table in order
        predicted = apply_request(act, key, word);
        pending_results.push_back(pinned ? pinned_result : predicted);
    endtask

    // drop valid and hold the sender until every owed result is back
    task automatic pause_until_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // mix of well-formed traffic aimed at live keys, plus some noise beats
    task automatic run_mixed(input int count, input int add_pct, input int remove_pct);
        int roll;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (roll < add_pct)
                issue_request(ACT_ADD, KEY_FIELD_W'($urandom), pick_word(), 1'b0, '0);
            else if (roll < add_pct + remove_pct)
                issue_request(ACT_REMOVE,
                              ($urandom_range(9) < 8) ? pick_live_key()
                                                      : KEY_FIELD_W'($urandom),
                              $urandom, 1'b0, '0);
            else if (roll < 90)
                issue_request(ACT_GET,
                              ($urandom_range(9) < 8) ? pick_live_key()
                                                      : KEY_FIELD_W'($urandom),
                              $urandom, 1'b0, '0);
            else
                issue_request(ACTION_W'($urandom_range(3)), KEY_FIELD_W'($urandom),
                              $urandom, 1'b0, '0);
        end
    endtask

    // receiver side: random stalls, or a long hold-off when one is requested
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // result checker, every beat taken is matched against the oldest owed result
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat arrived with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("issued_key", 32'(want.issued_key), 32'(res_ch.issued_key));
                check_field("read_value", want.read_value, res_ch.read_value);
                check_field("found", 32'(want.found), 32'(res_ch.found));
                check_field("full_res", 32'(want.full_res), 32'(res_ch.full_res));
                check_field("live_count", 32'(want.live_count), 32'(res_ch.live_count));
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.action    = ACT_ADD;
        req_ch.req_key   = '0;
        req_ch.req_value = '0;

        alloc_ptr  = 8'd1;
        busy_count = '0;
        for (int k = 0; k < 256; k++)
        begin
            key_busy[k] = 1'b0;
            key_word[k] = '0;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows, no idling; the block's clearing pass holds off the first beat
        for (int i = 0; i < PLAN_LEN; i++)
            issue_request(DIRECTED_PLAN[i].action, DIRECTED_PLAN[i].req_key,
                          DIRECTED_PLAN[i].req_value, DIRECTED_PLAN[i].pinned,
                          DIRECTED_PLAN[i].result);
        pause_until_drained();

        // back to back traffic, table grows
        run_mixed(150, 50, 20);
        pause_until_drained();

        // sender gaps, with a long receiver hold-off so the input backs up
        send_idle_pct = 50;
        hold_cycles = 300;
        run_mixed(100, 40, 25);
        pause_until_drained();

        // receiver stalls while the table fills to the brim and wraps the pointer
        send_idle_pct = 0;
        recv_stall_pct = 50;
        while (busy_count != TABLE_CAP)
            issue_request(ACT_ADD, KEY_FIELD_W'($urandom), pick_word(), 1'b0, '0);
        // adds on a full table must be refused
        repeat (4)
            issue_request(ACT_ADD, KEY_FIELD_W'($urandom), pick_word(), 1'b0, '0);
        run_mixed(60, 10, 60);
        pause_until_drained();

        // both sides idling, one more hold-off part way through
        send_idle_pct = 25;
        recv_stall_pct = 25;
        run_mixed(50, 45, 25);
        hold_cycles = 200;
        run_mixed(50, 45, 25);
        pause_until_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial
    begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
rtl/hkat_pkg.sv
rtl/hkat_if.sv
rtl/hkat_ctrl.sv
rtl/hkat_dp.sv
rtl/handle_key_allocator_table.sv
bench/tb_top.sv
